FILE: sv/ssc_pkg.sv
// Shared types and constants of the servo sweep controller.
`default_nettype none

package ssc_pkg;

   localparam int ANGLE_W    = 8;
   localparam int PULSE_W    = 12;
   localparam int POS_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_SET   = 2'd1,
      CMD_START = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_REVERSE = 2'd0,
      KIND_RESTART = 2'd1,
      KIND_SINGLE  = 2'd2,
      KIND_FREE    = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_LIMIT   = 3'd0,
      CSR_HIGH_LIMIT  = 3'd1,
      CSR_STEP_SIZE   = 3'd2,
      CSR_START_ANGLE = 3'd3,
      CSR_STOP_ANGLE  = 3'd4,
      CSR_SWEEP_KIND  = 3'd5,
      CSR_PULSE_MIN   = 3'd6,
      CSR_PULSE_MAX   = 3'd7
   } csr_idx_type;

   localparam logic [ANGLE_W-1:0] RST_LOW_LIMIT   = 8'd0;
   localparam logic [ANGLE_W-1:0] RST_HIGH_LIMIT  = 8'd180;
   localparam logic [ANGLE_W-1:0] RST_STEP_SIZE   = 8'd1;
   localparam logic [ANGLE_W-1:0] RST_START_ANGLE = 8'd0;
   localparam logic [ANGLE_W-1:0] RST_STOP_ANGLE  = 8'd180;
   localparam logic [PULSE_W-1:0] RST_PULSE_MIN   = 12'd544;
   localparam logic [PULSE_W-1:0] RST_PULSE_MAX   = 12'd2400;

endpackage

`default_nettype wire

FILE: sv/servo_sweep_controller.sv
// Top level of the servo sweep controller: sweep state, angle clamp and pulse mapping.
//
//   Channel  Direction  Handshake                    Payload
//   req      in         req_valid / req_ready        req_cmd, req_target_angle
//   rsp      out        rsp_valid / rsp_ready        rsp_angle, rsp_pulse_us, rsp_sweeping
//   csr      in         csr_wr_en                    csr_index, csr_wdata
//
// One word is accepted per cycle while req_ready is high, and each word yields one result word.
// The sweep state is updated in the cycle a word is accepted; the pulse width then
// takes two more stages, one for the angle by span product and one for the
// division by the full angle; the result is presented from the stage three registers.
// Reset clears the sweep state and the pipeline and loads the register defaults.
// A stalled result holds the pipeline, and req_ready drops only once all stages are full.
`default_nettype none

module servo_sweep_controller #(
   parameter int FULL_ANGLE = 180
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [1:0]                       req_cmd,
   input  wire logic [ssc_pkg::ANGLE_W-1:0]      req_target_angle,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [ssc_pkg::ANGLE_W-1:0]      rsp_angle,
   output      logic [ssc_pkg::PULSE_W-1:0]      rsp_pulse_us,
   output      logic                             rsp_sweeping,
   input  wire logic                             csr_wr_en,
   input  wire logic [ssc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ssc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW      = ssc_pkg::ANGLE_W;
   localparam int PW      = ssc_pkg::PULSE_W;
   localparam int XW      = ssc_pkg::POS_W;
   localparam int PROD_W  = AW + PW;
   localparam int SHIFT   = PROD_W + AW;
   localparam int RECIP_W = SHIFT + 1;
   localparam logic [AW-1:0] FULL_A = AW'(FULL_ANGLE);
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(FULL_ANGLE) - 64'd1) / 64'(FULL_ANGLE));

   // Configuration registers.
   logic [AW-1:0] low_limit_ff, high_limit_ff, step_size_ff, start_angle_ff, stop_angle_ff;
   logic [1:0]    sweep_kind_ff;
   logic [PW-1:0] pulse_min_ff, pulse_max_ff;

   // Sweep state.
   logic [AW-1:0] angle_ff, angle_in;
   logic          dir_up_ff, dir_up_in;
   logic          sweep_on_ff, sweep_on_in;
   logic [AW-1:0] range_start_ff, range_start_in;
   logic [AW-1:0] range_stop_ff, range_stop_in;

   // Pipeline.
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [AW-1:0]     s1_angle_ff, s2_angle_ff, s3_angle_ff;
   logic              s1_sweep_ff, s2_sweep_ff, s3_sweep_ff;
   logic [PROD_W-1:0] s2_mag_ff, s2_mag_in;
   logic              s2_neg_ff, s2_neg_in;
   logic [PW-1:0]     s3_pulse_ff, s3_pulse_in;
   logic              load3, load2, load1, req_fire;

   logic [AW-1:0]        lim_a, lim_b, lim_lo, lim_hi, rng_lo, rng_hi;
   logic signed [XW-1:0] moved, pos;
   logic                 above, below;
   logic signed [PW:0]   span;
   logic [PW-1:0]        span_mag;
   logic [PROD_W+RECIP_W-1:0] quot_full;
   logic [PW-1:0]        quot;

   function automatic logic [AW-1:0] clamp_angle(
      input logic signed [XW-1:0] v,
      input logic [AW-1:0]        lo,
      input logic [AW-1:0]        hi
   );
      logic [AW-1:0] r;
      if (v > $signed({{(XW-AW){1'b0}}, hi})) begin
         r = hi;
      end else if (v < $signed({{(XW-AW){1'b0}}, lo})) begin
         r = lo;
      end else begin
         r = v[AW-1:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff   <= ssc_pkg::RST_LOW_LIMIT;
         high_limit_ff  <= ssc_pkg::RST_HIGH_LIMIT;
         step_size_ff   <= ssc_pkg::RST_STEP_SIZE;
         start_angle_ff <= ssc_pkg::RST_START_ANGLE;
         stop_angle_ff  <= ssc_pkg::RST_STOP_ANGLE;
         sweep_kind_ff  <= ssc_pkg::KIND_REVERSE;
         pulse_min_ff   <= ssc_pkg::RST_PULSE_MIN;
         pulse_max_ff   <= ssc_pkg::RST_PULSE_MAX;
      end else if (csr_wr_en) begin
         unique case (ssc_pkg::csr_idx_type'(csr_index))
            ssc_pkg::CSR_LOW_LIMIT:   low_limit_ff   <= csr_wdata[AW-1:0];
            ssc_pkg::CSR_HIGH_LIMIT:  high_limit_ff  <= csr_wdata[AW-1:0];
            ssc_pkg::CSR_STEP_SIZE:   step_size_ff   <= csr_wdata[AW-1:0];
            ssc_pkg::CSR_START_ANGLE: start_angle_ff <= csr_wdata[AW-1:0];
            ssc_pkg::CSR_STOP_ANGLE:  stop_angle_ff  <= csr_wdata[AW-1:0];
            ssc_pkg::CSR_SWEEP_KIND:  sweep_kind_ff  <= csr_wdata[1:0];
            ssc_pkg::CSR_PULSE_MIN:   pulse_min_ff   <= csr_wdata[PW-1:0];
            ssc_pkg::CSR_PULSE_MAX:   pulse_max_ff   <= csr_wdata[PW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Limits are saturated to the full angle and swapped when inverted.
   assign lim_a  = (low_limit_ff > FULL_A) ? FULL_A : low_limit_ff;
   assign lim_b  = (high_limit_ff > FULL_A) ? FULL_A : high_limit_ff;
   assign lim_lo = (lim_b < lim_a) ? lim_b : lim_a;
   assign lim_hi = (lim_b < lim_a) ? lim_a : lim_b;

   assign rng_lo = (range_start_ff < range_stop_ff) ? range_start_ff : range_stop_ff;
   assign rng_hi = (range_start_ff < range_stop_ff) ? range_stop_ff : range_start_ff;

   assign moved = dir_up_ff
      ? $signed({{(XW-AW){1'b0}}, angle_ff}) + $signed({{(XW-AW){1'b0}}, step_size_ff})
      : $signed({{(XW-AW){1'b0}}, angle_ff}) - $signed({{(XW-AW){1'b0}}, step_size_ff});
   assign above = moved > $signed({{(XW-AW){1'b0}}, rng_hi});
   assign below = moved < $signed({{(XW-AW){1'b0}}, rng_lo});

   always_comb begin
      pos            = $signed({{(XW-AW){1'b0}}, angle_ff});
      dir_up_in      = dir_up_ff;
      sweep_on_in    = sweep_on_ff;
      range_start_in = range_start_ff;
      range_stop_in  = range_stop_ff;
      unique case (ssc_pkg::cmd_type'(req_cmd))
         ssc_pkg::CMD_TICK: begin
            if (sweep_on_ff) begin
               pos = moved;
               case (ssc_pkg::kind_type'(sweep_kind_ff))
                  ssc_pkg::KIND_REVERSE: begin
                     if (above) begin
                        dir_up_in = 1'b0;
                     end else if (below) begin
                        dir_up_in = 1'b1;
                     end
                  end
                  ssc_pkg::KIND_RESTART: begin
                     if (above || below) begin
                        pos = $signed({{(XW-AW){1'b0}}, range_start_ff});
                     end
                  end
                  ssc_pkg::KIND_SINGLE: begin
                     if (above || below) begin
                        sweep_on_in = 1'b0;
                        pos         = $signed({{(XW-AW){1'b0}}, range_stop_ff});
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ssc_pkg::CMD_SET: begin
            pos = $signed({{(XW-AW){1'b0}}, req_target_angle});
         end
         ssc_pkg::CMD_START: begin
            dir_up_in      = start_angle_ff < stop_angle_ff;
            range_start_in = clamp_angle($signed({{(XW-AW){1'b0}}, start_angle_ff}),
                                         lim_lo, lim_hi);
            range_stop_in  = clamp_angle($signed({{(XW-AW){1'b0}}, stop_angle_ff}),
                                         lim_lo, lim_hi);
            pos            = $signed({{(XW-AW){1'b0}}, range_start_in});
            sweep_on_in    = 1'b1;
         end
         ssc_pkg::CMD_STOP: begin
            sweep_on_in = 1'b0;
         end
         default: begin
         end
      endcase
      angle_in = clamp_angle(pos, lim_lo, lim_hi);
   end

   assign load3     = s2_valid_ff && (!s3_valid_ff || rsp_ready);
   assign load2     = s1_valid_ff && (!s2_valid_ff || load3);
   assign load1     = !s1_valid_ff || load2;
   assign req_ready = load1;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff       <= '0;
         dir_up_ff      <= 1'b0;
         sweep_on_ff    <= 1'b0;
         range_start_ff <= '0;
         range_stop_ff  <= '0;
      end else if (req_fire) begin
         angle_ff       <= angle_in;
         dir_up_ff      <= dir_up_in;
         sweep_on_ff    <= sweep_on_in;
         range_start_ff <= range_start_in;
         range_stop_ff  <= range_stop_in;
      end
   end

   // Stage two: magnitude of angle times span, sign kept apart.
   assign span      = $signed({1'b0, pulse_max_ff}) - $signed({1'b0, pulse_min_ff});
   assign span_mag  = span[PW] ? PW'(-span) : span[PW-1:0];
   assign s2_mag_in = PROD_W'(s1_angle_ff) * PROD_W'(span_mag);
   assign s2_neg_in = span[PW];

   // Stage three: division by the full angle through a reciprocal, truncated toward zero.
   assign quot_full   = (PROD_W+RECIP_W)'(s2_mag_ff) * (PROD_W+RECIP_W)'(RECIP);
   assign quot        = quot_full[SHIFT +: PW];
   assign s3_pulse_in = s2_neg_ff ? (pulse_min_ff - quot) : (pulse_min_ff + quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (load1) begin
            s1_valid_ff <= req_valid;
         end
         if (load2 || (s2_valid_ff && load3)) begin
            s2_valid_ff <= load2;
         end
         if (load3 || (s3_valid_ff && rsp_ready)) begin
            s3_valid_ff <= load3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_angle_ff <= angle_in;
         s1_sweep_ff <= sweep_on_in;
      end
      if (load2) begin
         s2_angle_ff <= s1_angle_ff;
         s2_sweep_ff <= s1_sweep_ff;
         s2_mag_ff   <= s2_mag_in;
         s2_neg_ff   <= s2_neg_in;
      end
      if (load3) begin
         s3_angle_ff <= s2_angle_ff;
         s3_sweep_ff <= s2_sweep_ff;
         s3_pulse_ff <= s3_pulse_in;
      end
   end

   assign rsp_valid    = s3_valid_ff;
   assign rsp_angle    = s3_angle_ff;
   assign rsp_pulse_us = s3_pulse_ff;
   assign rsp_sweeping = s3_sweep_ff;

endmodule

`default_nettype wire

FILE: sv/ssc_checker.sv
// Port-level checks of the servo sweep controller and their binding to the top level.
`default_nettype none

module ssc_checker #(
   parameter int FULL_ANGLE = 180
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [ssc_pkg::ANGLE_W-1:0] rsp_angle,
   input wire logic [ssc_pkg::PULSE_W-1:0] rsp_pulse_us,
   input wire logic                        rsp_sweeping
);

   // A result that is not taken stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle)
         && $stable(rsp_pulse_us) && $stable(rsp_sweeping))
      else $error("result word changed while stalled");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_angle) <= 32'(FULL_ANGLE)))
      else $error("angle beyond full range");

   // The pipeline is empty after reset, so no result can show before a word has gone through all stages.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("result word too soon after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("not ready after reset");

   // With nothing accepted and the result side free, the output drains.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !req_valid && rsp_ready ##1 !req_valid && rsp_ready ##1 !req_valid && rsp_ready
         |=> !rsp_valid)
      else $error("result word without an accepted word");

endmodule

bind servo_sweep_controller ssc_checker #(.FULL_ANGLE(FULL_ANGLE)) u_ssc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_angle    (rsp_angle),
   .rsp_pulse_us (rsp_pulse_us),
   .rsp_sweeping (rsp_sweeping)
);

`default_nettype wire
